@@ src/npos_pkg.sv @@
// shared types and constants for the nearest point order sort block
package npos_pkg;

	localparam int FRAME_W     = 16;
	localparam int DEF_CAPACITY = 64;
	localparam int DEF_COORD_W  = 32;

	// action codes of an input word
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// purpose of a table read
	typedef enum logic [1:0] {
		RD_REF,
		RD_DIST,
		RD_EMIT
	} rd_kind_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic     load_wr;
		logic     query_start;
		logic     rd_en;
		rd_kind_t rd_kind;
		logic     emit_found;
		logic     emit_last;
	} npos_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic dist_busy;
		logic sort_empty;
		logic sort_one;
		logic out_credit;
	} npos_sts_t;

endpackage

@@ src/npos_sorter.sv @@
// insertion sorter: a row of cells kept in ascending key order
module npos_sorter import npos_pkg::*; #(
	parameter int DEPTH = DEF_CAPACITY,
	parameter int KEY_W = 2 * DEF_COORD_W + 1,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             ins,
	input  logic [KEY_W-1:0] ins_key,
	input  logic [IDX_W-1:0] ins_idx,
	input  logic             pop,
	output logic [IDX_W-1:0] head_idx,
	output logic             empty,
	output logic             one
);

	logic [KEY_W-1:0] key_q [DEPTH];
	logic [IDX_W-1:0] idx_q [DEPTH];
	logic [DEPTH-1:0] vld_q;

	logic [DEPTH-1:0] lt;
	logic [DEPTH-1:0] lt_prev;
	logic [DEPTH-1:0] dn_vld;
	logic [DEPTH-1:0] up_vld;
	logic [KEY_W-1:0] dn_key [DEPTH];
	logic [KEY_W-1:0] up_key [DEPTH];
	logic [IDX_W-1:0] dn_idx [DEPTH];
	logic [IDX_W-1:0] up_idx [DEPTH];

	// per-cell compare and neighbor wiring; strict less keeps equal keys in arrival order
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		assign lt[g] = !vld_q[g] || (ins_key < key_q[g]);
		if (g == 0) begin : g_head
			assign lt_prev[g] = 1'b0;
			assign dn_vld[g]  = 1'b1;
			assign dn_key[g]  = ins_key;
			assign dn_idx[g]  = ins_idx;
		end else begin : g_body
			assign lt_prev[g] = lt[g-1];
			assign dn_vld[g]  = vld_q[g-1];
			assign dn_key[g]  = key_q[g-1];
			assign dn_idx[g]  = idx_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign up_vld[g] = 1'b0;
			assign up_key[g] = key_q[g];
			assign up_idx[g] = idx_q[g];
		end else begin : g_mid
			assign up_vld[g] = vld_q[g+1];
			assign up_key[g] = key_q[g+1];
			assign up_idx[g] = idx_q[g+1];
		end
	end

	// occupancy: insert grows the valid prefix, pop shifts it toward the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (ins) begin
			vld_q <= dn_vld;
		end else if (pop) begin
			vld_q <= up_vld;
		end
	end

	// cell contents
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (ins) begin
				if (lt_prev[i]) begin
					key_q[i] <= dn_key[i];
					idx_q[i] <= dn_idx[i];
				end else if (lt[i]) begin
					key_q[i] <= ins_key;
					idx_q[i] <= ins_idx;
				end
			end else if (pop) begin
				key_q[i] <= up_key[i];
				idx_q[i] <= up_idx[i];
			end
		end
	end

	assign head_idx = idx_q[0];
	assign empty    = !vld_q[0];
	assign one      = vld_q[0] && !vld_q[1];

	// insert and pop come from different phases of a query
	a_ins_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ins |-> !pop)
		else $error("sorter insert and pop in the same cycle");

	for (genvar g = 0; g < DEPTH - 1; g++) begin : g_chk
		a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
			vld_q[g+1] |-> vld_q[g])
			else $error("sorter valid cells not contiguous");
		a_order: assert property (@(posedge clk) disable iff (!arst_n)
			vld_q[g+1] |-> !(key_q[g+1] < key_q[g]))
			else $error("sorter cells out of order");
	end

endmodule

@@ src/npos_datapath.sv @@
// datapath: point table, reference pick, distance pipeline, sorter and output queue
module npos_datapath import npos_pkg::*; #(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int COORD_WIDTH = DEF_COORD_W,
	localparam int IDX_W = $clog2(CAPACITY)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  npos_cmd_t                     cmd,
	input  logic [IDX_W-1:0]              addr,
	input  logic [FRAME_W-1:0]            frame,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	output npos_sts_t                     sts,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [FRAME_W-1:0]            out_frame,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                          found,
	output logic                          last
);

	localparam int W      = COORD_WIDTH;
	localparam int ENT_W  = FRAME_W + 2 * W;
	localparam int LO_W   = (W + 1) / 2;
	localparam int HI_W   = W - LO_W;
	localparam int SQ_W   = 2 * W;
	localparam int KEY_W  = SQ_W + 1;
	localparam int OUT_W  = ENT_W + 2;

	// point table
	logic [ENT_W-1:0] mem_q [CAPACITY];
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] head_idx;

	// read stage
	logic             rd_vld_s1;
	rd_kind_t         rd_kind_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             rd_found_s1;
	logic             rd_last_s1;
	logic [ENT_W-1:0] rd_data_s1;

	logic [FRAME_W-1:0]   s1_frame;
	logic signed [W-1:0]  s1_x;
	logic signed [W-1:0]  s1_y;

	logic [FRAME_W-1:0]  qframe_q;
	logic signed [W-1:0] ref_x_q;
	logic signed [W-1:0] ref_y_q;

	// distance pipeline
	logic [W:0]          dxa, dxb, dya, dyb;
	logic [W-1:0]        mag_x, mag_y;
	logic                dist_vld_s2, dist_vld_s3, dist_vld_s4, dist_vld_s5;
	logic [IDX_W-1:0]    idx_s2, idx_s3, idx_s4, idx_s5;
	logic [W-1:0]        mag_x_s2, mag_y_s2;
	logic [2*LO_W-1:0]   ppx_ll_s3, ppy_ll_s3;
	logic [W-1:0]        ppx_lh_s3, ppy_lh_s3;
	logic [2*HI_W-1:0]   ppx_hh_s3, ppy_hh_s3;
	logic [SQ_W-1:0]     sq_x_s4, sq_y_s4;
	logic [KEY_W-1:0]    key_s5;

	// output queue
	logic             enq, deq, sort_pop;
	logic [OUT_W-1:0] enq_word;
	logic [OUT_W-1:0] out_word_q, skid_word_q;
	logic             out_vld_q, skid_vld_q;
	logic             load_out_new, load_out_skid, load_skid;
	logic [1:0]       fill;

	// table write and registered read; emit reads follow the sorter head
	assign rd_addr = (cmd.rd_kind == RD_EMIT) ? head_idx : addr;

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			mem_q[addr] <= {frame, pos_x, pos_y};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_kind_s1  <= cmd.rd_kind;
		rd_idx_s1   <= rd_addr;
		rd_found_s1 <= cmd.emit_found;
		rd_last_s1  <= cmd.emit_last;
	end

	assign s1_frame = rd_data_s1[ENT_W-1 -: FRAME_W];
	assign s1_x     = rd_data_s1[2*W-1 -: W];
	assign s1_y     = rd_data_s1[W-1:0];

	// query frame and reference point: entry 0 first, then any later frame match
	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			qframe_q <= frame;
		end
		if (rd_vld_s1 && rd_kind_s1 == RD_REF &&
		    (rd_idx_s1 == '0 || s1_frame == qframe_q)) begin
			ref_x_q <= s1_x;
			ref_y_q <= s1_y;
		end
	end

	// absolute differences, both subtraction orders side by side
	assign dxa   = {s1_x[W-1], s1_x} - {ref_x_q[W-1], ref_x_q};
	assign dxb   = {ref_x_q[W-1], ref_x_q} - {s1_x[W-1], s1_x};
	assign dya   = {s1_y[W-1], s1_y} - {ref_y_q[W-1], ref_y_q};
	assign dyb   = {ref_y_q[W-1], ref_y_q} - {s1_y[W-1], s1_y};
	assign mag_x = dxa[W] ? dxb[W-1:0] : dxa[W-1:0];
	assign mag_y = dya[W] ? dyb[W-1:0] : dya[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_vld_s2 <= 1'b0;
			dist_vld_s3 <= 1'b0;
			dist_vld_s4 <= 1'b0;
			dist_vld_s5 <= 1'b0;
		end else begin
			dist_vld_s2 <= rd_vld_s1 && rd_kind_s1 == RD_DIST && (s1_frame < qframe_q);
			dist_vld_s3 <= dist_vld_s2;
			dist_vld_s4 <= dist_vld_s3;
			dist_vld_s5 <= dist_vld_s4;
		end
	end

	// magnitudes, then half-word partial products, square sums, key
	always_ff @(posedge clk) begin
		mag_x_s2  <= mag_x;
		mag_y_s2  <= mag_y;
		idx_s2    <= rd_idx_s1;

		ppx_ll_s3 <= mag_x_s2[LO_W-1:0] * mag_x_s2[LO_W-1:0];
		ppx_lh_s3 <= mag_x_s2[LO_W-1:0] * mag_x_s2[W-1:LO_W];
		ppx_hh_s3 <= mag_x_s2[W-1:LO_W] * mag_x_s2[W-1:LO_W];
		ppy_ll_s3 <= mag_y_s2[LO_W-1:0] * mag_y_s2[LO_W-1:0];
		ppy_lh_s3 <= mag_y_s2[LO_W-1:0] * mag_y_s2[W-1:LO_W];
		ppy_hh_s3 <= mag_y_s2[W-1:LO_W] * mag_y_s2[W-1:LO_W];
		idx_s3    <= idx_s2;

		sq_x_s4   <= (SQ_W'(ppx_hh_s3) << (2 * LO_W)) + (SQ_W'(ppx_lh_s3) << (LO_W + 1))
		             + SQ_W'(ppx_ll_s3);
		sq_y_s4   <= (SQ_W'(ppy_hh_s3) << (2 * LO_W)) + (SQ_W'(ppy_lh_s3) << (LO_W + 1))
		             + SQ_W'(ppy_ll_s3);
		idx_s4    <= idx_s3;

		key_s5    <= {1'b0, sq_x_s4} + {1'b0, sq_y_s4};
		idx_s5    <= idx_s4;
	end

	// sorted list of candidate entries
	assign sort_pop = cmd.rd_en && cmd.rd_kind == RD_EMIT && cmd.emit_found;

	npos_sorter #(
		.DEPTH (CAPACITY),
		.KEY_W (KEY_W)
	) u_sorter (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (cmd.query_start),
		.ins      (dist_vld_s5),
		.ins_key  (key_s5),
		.ins_idx  (idx_s5),
		.pop      (sort_pop),
		.head_idx (head_idx),
		.empty    (sts.sort_empty),
		.one      (sts.sort_one)
	);

	// two-word output queue: head register plus skid register
	assign enq      = rd_vld_s1 && rd_kind_s1 == RD_EMIT;
	assign enq_word = {rd_found_s1 ? rd_data_s1 : {ENT_W{1'b0}}, rd_found_s1, rd_last_s1};
	assign deq      = out_vld_q && !out_stall;

	assign load_out_new  = enq && (!out_vld_q || (deq && !skid_vld_q));
	assign load_out_skid = deq && skid_vld_q;
	assign load_skid     = enq && !load_out_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (load_out_new || load_out_skid) begin
				out_vld_q <= 1'b1;
			end else if (deq) begin
				out_vld_q <= 1'b0;
			end
			if (load_skid) begin
				skid_vld_q <= 1'b1;
			end else if (load_out_skid) begin
				skid_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_new) begin
			out_word_q <= enq_word;
		end else if (load_out_skid) begin
			out_word_q <= skid_word_q;
		end
		if (load_skid) begin
			skid_word_q <= enq_word;
		end
	end

	// a new emit read may issue when its word is sure to find room
	assign fill = 2'(out_vld_q) + 2'(skid_vld_q) + 2'(enq);

	assign sts.out_credit = fill <= (2'(deq) + 2'd1);
	assign sts.dist_busy  = (rd_vld_s1 && rd_kind_s1 == RD_DIST) || dist_vld_s2 ||
	                        dist_vld_s3 || dist_vld_s4 || dist_vld_s5;

	assign out_valid = out_vld_q;
	assign out_frame = out_word_q[OUT_W-1 -: FRAME_W];
	assign out_x     = out_word_q[2*W+1 -: W];
	assign out_y     = out_word_q[W+1 -: W];
	assign found     = out_word_q[1];
	assign last      = out_word_q[0];

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		enq |-> !(out_vld_q && skid_vld_q && !deq))
		else $error("output queue overflow");

endmodule

@@ src/npos_ctrl.sv @@
// controller: load handling, scan sequencing and result emission
module npos_ctrl import npos_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int CNT_W = $clog2(CAPACITY + 1),
	localparam int IDX_W = $clog2(CAPACITY)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             action,
	output logic             in_stall,
	input  npos_sts_t        sts,
	output npos_cmd_t        cmd,
	output logic [IDX_W-1:0] addr
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REF,
		ST_DIST,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             scan_more;
	logic             table_full;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && (state_q == ST_IDLE);
	assign scan_more  = (cnt_q != count_q);
	assign table_full = (count_q == CNT_W'(CAPACITY));

	// command decode
	always_comb begin
		cmd  = '0;
		addr = cnt_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				addr = count_q[IDX_W-1:0];
				if (accept) begin
					if (action == ACT_LOAD) begin
						cmd.load_wr = !table_full;
					end else begin
						cmd.query_start = 1'b1;
					end
				end
			end
			ST_REF: begin
				cmd.rd_en   = scan_more;
				cmd.rd_kind = RD_REF;
			end
			ST_DIST: begin
				cmd.rd_en   = scan_more;
				cmd.rd_kind = RD_DIST;
			end
			ST_EMIT: begin
				cmd.rd_kind    = RD_EMIT;
				cmd.rd_en      = sts.out_credit;
				cmd.emit_found = !sts.sort_empty;
				cmd.emit_last  = sts.sort_empty || sts.sort_one;
			end
			default: begin
			end
		endcase
	end

	// state, scan counter and table fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_LOAD) begin
							if (!table_full) begin
								count_q <= count_q + 1'b1;
							end
						end else begin
							state_q <= ST_REF;
							cnt_q   <= '0;
						end
					end
				end
				ST_REF: begin
					if (scan_more) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_DIST;
						cnt_q   <= '0;
					end
				end
				ST_DIST: begin
					if (scan_more) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!sts.dist_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sts.out_credit && cmd.emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("table fill count beyond capacity");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && state_q != ST_EMIT) |-> (cnt_q < count_q))
		else $error("scan read past the filled part of the table");

endmodule

@@ src/nearest_point_order_sort.sv @@
// top level of the nearest point order sort block
//
// Input channel (in_valid / in_stall): a word with action = load appends
// (frame, pos_x, pos_y) to the point table; loads beyond CAPACITY entries are
// dropped. A word with action = query names a frame; the block answers with
// every stored point of smaller frame, in ascending squared distance to the
// reference point (last entry of that frame, else entry 0), equal distances
// in load order. With none, one word with found = 0 is sent.
// Output channel (out_valid / out_stall): one word per returned point; last
// marks the final word of a query.
// Sequence: a load writes one table entry. A query with n stored points runs
// a reference scan of n reads, then a distance scan of n reads through a
// squaring pipeline (magnitudes, partial products, squares, key) into an
// insertion sorter, then emits one word per cycle while the two-word output
// queue has room, bounded by the single table read port. The input is
// stalled from query acceptance until the last result has been issued.
// Reset empties the table. A stalled receiver holds the current word.
module nearest_point_order_sort import npos_pkg::*; #(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int COORD_WIDTH = DEF_COORD_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [FRAME_W-1:0]            frame,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [FRAME_W-1:0]            out_frame,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                          found,
	output logic                          last
);

	localparam int IDX_W = $clog2(CAPACITY);

	npos_cmd_t        cmd;
	npos_sts_t        sts;
	logic [IDX_W-1:0] addr;

	// sequencing
	npos_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd),
		.addr     (addr)
	);

	// table, distance pipeline, sorter and output queue
	npos_datapath #(
		.CAPACITY    (CAPACITY),
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.frame     (frame),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_frame (out_frame),
		.out_x     (out_x),
		.out_y     (out_y),
		.found     (found),
		.last      (last)
	);

endmodule

@@ verif/npos_checker.sv @@
`timescale 1ns / 1ps
// checker for the nearest point order sort block: point table model, distance ranking, word compare
module npos_checker import npos_pkg::*; #(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int COORD_WIDTH = DEF_COORD_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          action,
	input  logic [FRAME_W-1:0]            frame,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [FRAME_W-1:0]            out_frame,
	input  logic signed [COORD_WIDTH-1:0] out_x,
	input  logic signed [COORD_WIDTH-1:0] out_y,
	input  logic                          found,
	input  logic                          last,
	output int                            mismatches,
	output int                            pending
);

	// squared distance needs two coordinate widths plus carry room
	localparam int KEY_W = 2 * COORD_WIDTH + 3;

	typedef struct {
		logic [FRAME_W-1:0]            frame;
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic                          found;
		logic                          last;
	} point_word_t;

	point_word_t                   answer_q[$];
	point_word_t                   exp_word;
	logic [FRAME_W-1:0]            tbl_frame[CAPACITY];
	logic signed [COORD_WIDTH-1:0] tbl_x[CAPACITY];
	logic signed [COORD_WIDTH-1:0] tbl_y[CAPACITY];
	int                            tbl_count;
	int                            bad_words;

	initial begin
		mismatches = 0;
		pending    = 0;
		bad_words  = 0;
		tbl_count  = 0;
	end

	// exact squared euclidean distance from a stored point to the reference
	function automatic logic [KEY_W-1:0] dist_sq(input int idx,
			input logic signed [COORD_WIDTH-1:0] rx, input logic signed [COORD_WIDTH-1:0] ry);
		logic signed [COORD_WIDTH:0] dx;
		logic signed [COORD_WIDTH:0] dy;
		logic [KEY_W-1:0]            mx;
		logic [KEY_W-1:0]            my;
		dx = tbl_x[idx] - rx;
		dy = tbl_y[idx] - ry;
		mx = (dx < 0) ? -dx : dx;
		my = (dy < 0) ? -dy : dy;
		return mx * mx + my * my;
	endfunction

	// queue the answer words of a query: earlier frames by distance, load order on ties
	function automatic void rank_points(input logic [FRAME_W-1:0] q);
		logic signed [COORD_WIDTH-1:0] rx;
		logic signed [COORD_WIDTH-1:0] ry;
		logic [KEY_W-1:0]              keys[CAPACITY];
		int                            order[CAPACITY];
		logic [KEY_W-1:0]              k;
		point_word_t                   w;
		int                            m;
		int                            i;
		int                            j;
		rx = '0;
		ry = '0;
		m  = 0;
		if (tbl_count > 0) begin
			rx = tbl_x[0];
			ry = tbl_y[0];
		end
		// reference is the last entry of the queried frame, else entry 0
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_frame[i] == q) begin
				rx = tbl_x[i];
				ry = tbl_y[i];
			end
		end
		// stable insertion sort on distance
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_frame[i] < q) begin
				k = dist_sq(i, rx, ry);
				j = m;
				while (j > 0 && k < keys[j-1]) begin
					keys[j]  = keys[j-1];
					order[j] = order[j-1];
					j--;
				end
				keys[j]  = k;
				order[j] = i;
				m++;
			end
		end
		if (m == 0) begin
			w.frame = '0;
			w.x     = '0;
			w.y     = '0;
			w.found = 1'b0;
			w.last  = 1'b1;
			answer_q.insert(answer_q.size(), w);
		end else begin
			for (i = 0; i < m; i++) begin
				w.frame = tbl_frame[order[i]];
				w.x     = tbl_x[order[i]];
				w.y     = tbl_y[order[i]];
				w.found = 1'b1;
				w.last  = (i == m - 1);
				answer_q.insert(answer_q.size(), w);
			end
		end
	endfunction

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_count = 0;
			answer_q.delete();
		end else begin
			// accepted input word
			if (in_valid && !in_stall) begin
				if (action == ACT_LOAD) begin
					if (tbl_count < CAPACITY) begin
						tbl_frame[tbl_count] = frame;
						tbl_x[tbl_count]     = pos_x;
						tbl_y[tbl_count]     = pos_y;
						tbl_count++;
					end
				end else begin
					rank_points(frame);
				end
			end
			// accepted result word
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("%0t: unexpected result word: frame %0d x %0d y %0d found %0b last %0b",
							$time, out_frame, out_x, out_y, found, last);
				end else begin
					exp_word = answer_q.pop_front();
					if (out_frame !== exp_word.frame || out_x !== exp_word.x ||
							out_y !== exp_word.y || found !== exp_word.found ||
							last !== exp_word.last) begin
						bad_words++;
						if (bad_words <= 10) begin
							$display("%0t: result mismatch: expected frame %0d x %0d y %0d found %0b last %0b",
								$time, exp_word.frame, exp_word.x, exp_word.y,
								exp_word.found, exp_word.last);
							$display("%0t:                  got frame %0d x %0d y %0d found %0b last %0b",
								$time, out_frame, out_x, out_y, found, last);
						end
					end
				end
			end
		end
		mismatches <= bad_words;
		pending    <= answer_q.size();
	end

endmodule

@@ verif/nearest_point_order_sort_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the nearest point order sort block: stimulus, flow control and verdict
module nearest_point_order_sort_tb;
	import npos_pkg::*;

	localparam int CAP          = DEF_CAPACITY;
	localparam int CW           = DEF_COORD_W;
	localparam int RANDOM_WORDS = 142;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

	// receiver stall patterns
	typedef enum int {
		FLOW_FREE,
		FLOW_COIN,
		FLOW_HEAVY,
		FLOW_PERIODIC
	} flow_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 action;
	logic [FRAME_W-1:0]   frame;
	logic signed [CW-1:0] pos_x;
	logic signed [CW-1:0] pos_y;
	logic                 out_valid;
	logic                 out_stall;
	logic [FRAME_W-1:0]   out_frame;
	logic signed [CW-1:0] out_x;
	logic signed [CW-1:0] out_y;
	logic                 found;
	logic                 last;
	int                   mismatches;
	int                   pending;

	int                   burst_left;
	int                   loads_taken;
	int                   cycle_count;
	logic                 long_hold_req;
	logic [FRAME_W-1:0]   loaded_frames[$];

	nearest_point_order_sort #(.CAPACITY(CAP), .COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .frame(frame), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_frame(out_frame), .out_x(out_x), .out_y(out_y), .found(found), .last(last)
	);

	npos_checker #(.CAPACITY(CAP), .COORD_WIDTH(CW)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .frame(frame), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_frame(out_frame), .out_x(out_x), .out_y(out_y), .found(found), .last(last),
		.mismatches(mismatches), .pending(pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// coordinate: often small so distances tie, some wide and some extreme
	function automatic logic signed [CW-1:0] pick_coord();
		int                   sel;
		int                   v;
		logic signed [CW-1:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			v = $urandom_range(0, 128);
			c = CW'(v - 64);
		end else if (sel < 55) begin
			v = $urandom_range(0, 131072);
			c = CW'(v - 65536);
		end else if (sel < 85) begin
			c = CW'({$urandom, $urandom});
		end else begin
			case ($urandom_range(0, 3))
				0:       c = C_MIN;
				1:       c = C_MAX;
				2:       c = '0;
				default: c = '1;
			endcase
		end
		return c;
	endfunction

	// frame of a loaded point: small range for repeats, full range for the bits
	function automatic logic [FRAME_W-1:0] pick_load_frame();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return FRAME_W'($urandom_range(0, 48));
		if (sel < 90)
			return FRAME_W'($urandom_range(0, 65535));
		return $urandom_range(0, 1) ? '1 : '0;
	endfunction

	// queried frame: mostly a stored frame or just above one
	function automatic logic [FRAME_W-1:0] pick_query_frame();
		int sel;
		sel = $urandom_range(0, 99);
		if (loaded_frames.size() > 0 && sel < 45)
			return loaded_frames[$urandom_range(0, loaded_frames.size() - 1)];
		if (loaded_frames.size() > 0 && sel < 65)
			return loaded_frames[$urandom_range(0, loaded_frames.size() - 1)] + 1'b1;
		if (sel < 85)
			return FRAME_W'($urandom_range(0, 48));
		if (sel < 93)
			return FRAME_W'($urandom_range(0, 65535));
		return $urandom_range(0, 1) ? '1 : '0;
	endfunction

	// offer one input word in bursts, return at the accepting edge
	task automatic offer_word(input logic act, input logic [FRAME_W-1:0] fr,
			input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		action   <= act;
		frame    <= fr;
		pos_x    <= x;
		pos_y    <= y;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (act == ACT_LOAD && loads_taken < CAP) begin
			loaded_frames.insert(loaded_frames.size(), fr);
			loads_taken++;
		end
	endtask

	// receiver: changing stall patterns and one long hold-off
	initial begin
		flow_mode_t mode;
		int         mode_left;
		int         phase;
		logic       hold_done;
		out_stall = 1'b0;
		mode      = FLOW_FREE;
		mode_left = 0;
		phase     = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = flow_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				phase++;
				case (mode)
					FLOW_FREE:  out_stall <= 1'b0;
					FLOW_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
					FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:    out_stall <= (phase % 5 < 2);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		int   n_random;
		logic is_load;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		action        = ACT_LOAD;
		frame         = '0;
		pos_x         = '0;
		pos_y         = '0;
		long_hold_req = 1'b0;
		burst_left    = 0;
		loads_taken   = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// query on an empty table
		offer_word(ACT_QUERY, 16'd7, C_MAX, C_MIN);
		// extreme coordinates and frames
		offer_word(ACT_LOAD, 16'd10, C_MIN, C_MAX);
		offer_word(ACT_LOAD, 16'hFFFF, C_MAX, C_MIN);
		offer_word(ACT_LOAD, 16'd0, '0, '0);
		offer_word(ACT_LOAD, 16'd3, '1, '1);
		// frame 20 twice, the later copy at the origin is the reference
		offer_word(ACT_LOAD, 16'd20, 16, -16);
		offer_word(ACT_LOAD, 16'd7, 48, -16);
		offer_word(ACT_LOAD, 16'd8, 16, 16);
		offer_word(ACT_LOAD, 16'd20, 0, 0);
		// equal distances around the origin
		offer_word(ACT_LOAD, 16'd9, -32, 0);
		offer_word(ACT_LOAD, 16'd1, 32, 0);
		offer_word(ACT_LOAD, 16'd2, 0, -32);
		// nothing earlier than frame 0
		offer_word(ACT_QUERY, 16'd0, '0, '0);
		// repeated frame as reference
		offer_word(ACT_QUERY, 16'd20, C_MIN, '1);
		// frame not stored, entry 0 is the reference
		offer_word(ACT_QUERY, 16'd4, '0, C_MAX);
		// widest distances
		offer_word(ACT_QUERY, 16'hFFFF, '1, '0);
		offer_word(ACT_QUERY, 16'd11, '0, '0);
		offer_word(ACT_QUERY, 16'd3, '0, '0);

		// random mix: fill the table, then mostly queries and some dropped loads
		n_random = 0;
		while (n_random < RANDOM_WORDS) begin
			if (loads_taken < CAP)
				is_load = ($urandom_range(0, 99) < 60);
			else
				is_load = ($urandom_range(0, 99) < 12);
			if (is_load) begin
				if (loads_taken < CAP)
					n_random++;
				offer_word(ACT_LOAD, pick_load_frame(), pick_coord(), pick_coord());
			end else begin
				n_random++;
				if (loads_taken >= 24)
					long_hold_req = 1'b1;
				offer_word(ACT_QUERY, pick_query_frame(), pick_coord(), pick_coord());
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
